/* rtl/assert_macros.svh */
// Assertion macros used by the port checker of the quaternion unit.
// Depends on nothing; the user supplies clock and reset names.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while the reset is low.
`define QAU_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Clocked assertion that is also checked during reset.
`define QAU_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

/* rtl/qau_pkg.sv */
// Package of the quaternion arithmetic unit: word types, operation codes,
// stage structs and fixed-point helper functions. Depends on nothing.
package qau_pkg;

  localparam int FracBits = 16;

  typedef logic signed [31:0] fx_t;
  typedef logic signed [63:0] wide_t;

  localparam wide_t OneFx = 64'sd1 <<< FracBits;
  localparam wide_t MaxFx = 64'sh0000_0000_7FFF_FFFF;
  localparam wide_t MinFx = 64'shFFFF_FFFF_8000_0000;

  typedef enum logic [2:0] {
    KindAdd     = 3'd0,
    KindSub     = 3'd1,
    KindScale   = 3'd2,
    KindProduct = 3'd3,
    KindConj    = 3'd4,
    KindNormSq  = 3'd5,
    KindRotate  = 3'd6,
    KindMatrix  = 3'd7
  } kind_e;

  typedef struct packed {
    logic [2:0] kind;
    fx_t a_w;
    fx_t a_x;
    fx_t a_y;
    fx_t a_z;
    fx_t b_w;
    fx_t b_x;
    fx_t b_y;
    fx_t b_z;
  } in_t;

  typedef struct packed {
    fx_t  r0;
    fx_t  r1;
    fx_t  r2;
    fx_t  r3;
    fx_t  r4;
    fx_t  r5;
    fx_t  r6;
    fx_t  r7;
    fx_t  r8;
    logic overflow;
  } out_t;

  typedef struct packed {
    logic [2:0]       kind;
    fx_t [3:0]        a;
    fx_t [3:0]        b;
    wide_t [15:0]     p;
  } st1_t;

  typedef struct packed {
    logic [2:0]       kind;
    fx_t [3:0]        a;
    fx_t [2:0]        v;
    fx_t [2:0]        t;
    logic             tovf;
    wide_t [8:0]      res;
  } st2_t;

  typedef struct packed {
    logic [2:0]       kind;
    fx_t [2:0]        v;
    logic             tovf;
    wide_t [8:0]      res;
    wide_t [8:0]      q;
  } st3_t;

  typedef struct packed {
    logic ovf;
    fx_t  val;
  } sat_t;

  function automatic wide_t fmul(input fx_t x, input fx_t y);
    wide_t p;
    p = wide_t'(x) * wide_t'(y);
    return p >>> FracBits;
  endfunction

  function automatic sat_t sat32(input wide_t v);
    sat_t s;
    if (v > MaxFx) begin
      s.ovf = 1'b1;
      s.val = fx_t'(MaxFx);
    end else if (v < MinFx) begin
      s.ovf = 1'b1;
      s.val = fx_t'(MinFx);
    end else begin
      s.ovf = 1'b0;
      s.val = v[31:0];
    end
    return s;
  endfunction

endpackage

/* rtl/qau_mul1.sv */
// First stage: operand selection per operation and sixteen products.
// Depends on qau_pkg.
module qau_mul1 (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  qau_pkg::in_t  data_i,
  output logic          valid_o,
  output qau_pkg::st1_t data_o
);
  import qau_pkg::*;

  fx_t   ma [16];
  fx_t   mb [16];
  st1_t  data_d;
  st1_t  data_q;
  logic  valid_q;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      ma[i] = '0;
      mb[i] = '0;
    end
    unique case (kind_e'(data_i.kind))
      KindScale: begin
        ma[0] = data_i.a_w; mb[0] = data_i.b_w;
        ma[1] = data_i.a_x; mb[1] = data_i.b_w;
        ma[2] = data_i.a_y; mb[2] = data_i.b_w;
        ma[3] = data_i.a_z; mb[3] = data_i.b_w;
      end
      KindProduct: begin
        ma[0]  = data_i.a_w; mb[0]  = data_i.b_w;
        ma[1]  = data_i.a_x; mb[1]  = data_i.b_x;
        ma[2]  = data_i.a_y; mb[2]  = data_i.b_y;
        ma[3]  = data_i.a_z; mb[3]  = data_i.b_z;
        ma[4]  = data_i.a_w; mb[4]  = data_i.b_x;
        ma[5]  = data_i.a_x; mb[5]  = data_i.b_w;
        ma[6]  = data_i.a_y; mb[6]  = data_i.b_z;
        ma[7]  = data_i.a_z; mb[7]  = data_i.b_y;
        ma[8]  = data_i.a_w; mb[8]  = data_i.b_y;
        ma[9]  = data_i.a_y; mb[9]  = data_i.b_w;
        ma[10] = data_i.a_z; mb[10] = data_i.b_x;
        ma[11] = data_i.a_x; mb[11] = data_i.b_z;
        ma[12] = data_i.a_w; mb[12] = data_i.b_z;
        ma[13] = data_i.a_z; mb[13] = data_i.b_w;
        ma[14] = data_i.a_x; mb[14] = data_i.b_y;
        ma[15] = data_i.a_y; mb[15] = data_i.b_x;
      end
      KindNormSq: begin
        ma[0] = data_i.a_w; mb[0] = data_i.a_w;
        ma[1] = data_i.a_x; mb[1] = data_i.a_x;
        ma[2] = data_i.a_y; mb[2] = data_i.a_y;
        ma[3] = data_i.a_z; mb[3] = data_i.a_z;
      end
      KindRotate: begin
        ma[0] = data_i.a_y; mb[0] = data_i.b_z;
        ma[1] = data_i.a_z; mb[1] = data_i.b_y;
        ma[2] = data_i.a_z; mb[2] = data_i.b_x;
        ma[3] = data_i.a_x; mb[3] = data_i.b_z;
        ma[4] = data_i.a_x; mb[4] = data_i.b_y;
        ma[5] = data_i.a_y; mb[5] = data_i.b_x;
      end
      KindMatrix: begin
        ma[0] = data_i.a_x; mb[0] = data_i.a_x;
        ma[1] = data_i.a_y; mb[1] = data_i.a_y;
        ma[2] = data_i.a_z; mb[2] = data_i.a_z;
        ma[3] = data_i.a_x; mb[3] = data_i.a_y;
        ma[4] = data_i.a_x; mb[4] = data_i.a_z;
        ma[5] = data_i.a_y; mb[5] = data_i.a_z;
        ma[6] = data_i.a_w; mb[6] = data_i.a_x;
        ma[7] = data_i.a_w; mb[7] = data_i.a_y;
        ma[8] = data_i.a_w; mb[8] = data_i.a_z;
      end
      KindAdd, KindSub, KindConj: begin
      end
    endcase
    data_d.kind = data_i.kind;
    data_d.a    = {data_i.a_z, data_i.a_y, data_i.a_x, data_i.a_w};
    data_d.b    = {data_i.b_z, data_i.b_y, data_i.b_x, data_i.b_w};
    for (int i = 0; i < 16; i++) begin
      data_d.p[i] = fmul(ma[i], mb[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* rtl/qau_sum1.sv */
// Second stage: sums of products per operation, and the saturated rotation
// vector t. Depends on qau_pkg.
module qau_sum1 (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  qau_pkg::st1_t data_i,
  output logic          valid_o,
  output qau_pkg::st2_t data_o
);
  import qau_pkg::*;

  wide_t a [4];
  wide_t b [4];
  wide_t p [16];
  sat_t  tx;
  sat_t  ty;
  sat_t  tz;
  st2_t  data_d;
  st2_t  data_q;
  logic  valid_q;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      a[i] = wide_t'(data_i.a[i]);
      b[i] = wide_t'(data_i.b[i]);
    end
    for (int i = 0; i < 16; i++) begin
      p[i] = data_i.p[i];
    end
    tx = sat32((p[0] - p[1]) <<< 1);
    ty = sat32((p[2] - p[3]) <<< 1);
    tz = sat32((p[4] - p[5]) <<< 1);
    data_d.kind = data_i.kind;
    data_d.a    = data_i.a;
    data_d.v    = data_i.b[3:1];
    data_d.t    = {tz.val, ty.val, tx.val};
    data_d.tovf = 1'b0;
    data_d.res  = '0;
    unique case (kind_e'(data_i.kind))
      KindAdd: begin
        for (int i = 0; i < 4; i++) data_d.res[i] = a[i] + b[i];
      end
      KindSub: begin
        for (int i = 0; i < 4; i++) data_d.res[i] = a[i] - b[i];
      end
      KindScale: begin
        for (int i = 0; i < 4; i++) data_d.res[i] = p[i];
      end
      KindProduct: begin
        data_d.res[0] = p[0] - p[1] - p[2] - p[3];
        data_d.res[1] = p[4] + p[5] + p[6] - p[7];
        data_d.res[2] = p[8] + p[9] + p[10] - p[11];
        data_d.res[3] = p[12] + p[13] + p[14] - p[15];
      end
      KindConj: begin
        data_d.res[0] = a[0];
        data_d.res[1] = -a[1];
        data_d.res[2] = -a[2];
        data_d.res[3] = -a[3];
      end
      KindNormSq: begin
        data_d.res[0] = p[0] + p[1] + p[2] + p[3];
      end
      KindRotate: begin
        data_d.tovf = tx.ovf | ty.ovf | tz.ovf;
      end
      KindMatrix: begin
        data_d.res[0] = OneFx - ((p[1] + p[2]) <<< 1);
        data_d.res[1] = (p[3] + p[8]) <<< 1;
        data_d.res[2] = (p[4] - p[7]) <<< 1;
        data_d.res[3] = (p[3] - p[8]) <<< 1;
        data_d.res[4] = OneFx - ((p[0] + p[2]) <<< 1);
        data_d.res[5] = (p[5] + p[6]) <<< 1;
        data_d.res[6] = (p[4] + p[7]) <<< 1;
        data_d.res[7] = (p[5] - p[6]) <<< 1;
        data_d.res[8] = OneFx - ((p[0] + p[1]) <<< 1);
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* rtl/qau_mul2.sv */
// Third stage: the nine products of operand A with the rotation vector t.
// Depends on qau_pkg.
module qau_mul2 (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  qau_pkg::st2_t data_i,
  output logic          valid_o,
  output qau_pkg::st3_t data_o
);
  import qau_pkg::*;

  st3_t data_d;
  st3_t data_q;
  logic valid_q;

  always_comb begin
    data_d.kind = data_i.kind;
    data_d.v    = data_i.v;
    data_d.tovf = data_i.tovf;
    data_d.res  = data_i.res;
    data_d.q[0] = fmul(data_i.a[0], data_i.t[0]);
    data_d.q[1] = fmul(data_i.a[2], data_i.t[2]);
    data_d.q[2] = fmul(data_i.a[3], data_i.t[1]);
    data_d.q[3] = fmul(data_i.a[0], data_i.t[1]);
    data_d.q[4] = fmul(data_i.a[3], data_i.t[0]);
    data_d.q[5] = fmul(data_i.a[1], data_i.t[2]);
    data_d.q[6] = fmul(data_i.a[0], data_i.t[2]);
    data_d.q[7] = fmul(data_i.a[1], data_i.t[1]);
    data_d.q[8] = fmul(data_i.a[2], data_i.t[0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* rtl/qau_sum2.sv */
// Fourth stage: rotation sums, final saturation and the output register.
// Depends on qau_pkg.
module qau_sum2 (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  qau_pkg::st3_t data_i,
  output logic          valid_o,
  output qau_pkg::out_t data_o
);
  import qau_pkg::*;

  wide_t res [9];
  sat_t  s   [9];
  logic  ovf;
  out_t  data_d;
  out_t  data_q;
  logic  valid_q;

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      res[i] = data_i.res[i];
    end
    if (kind_e'(data_i.kind) == KindRotate) begin
      res[0] = wide_t'(data_i.v[0]) + data_i.q[0] + data_i.q[1] - data_i.q[2];
      res[1] = wide_t'(data_i.v[1]) + data_i.q[3] + data_i.q[4] - data_i.q[5];
      res[2] = wide_t'(data_i.v[2]) + data_i.q[6] + data_i.q[7] - data_i.q[8];
    end
    ovf = data_i.tovf;
    for (int i = 0; i < 9; i++) begin
      s[i] = sat32(res[i]);
      ovf  = ovf | s[i].ovf;
    end
    data_d.r0       = s[0].val;
    data_d.r1       = s[1].val;
    data_d.r2       = s[2].val;
    data_d.r3       = s[3].val;
    data_d.r4       = s[4].val;
    data_d.r5       = s[5].val;
    data_d.r6       = s[6].val;
    data_d.r7       = s[7].val;
    data_d.r8       = s[8].val;
    data_d.overflow = ovf;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* rtl/quaternion_arithmetic_unit_top.sv */
// Fixed-point quaternion ALU with a four-stage pipeline: an accepted word passes the
// registers of mul1, sum1, mul2 and sum2 in that order, and a new word is taken
// every cycle while the consumer is ready. The two multiplier layers of the
// rotate operation set the depth. While a result waits for the consumer, the
// whole pipeline holds.
// Depends on qau_pkg and the four stage modules.
module quaternion_arithmetic_unit_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  qau_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output qau_pkg::out_t out_data_o
);
  import qau_pkg::*;

  logic en;
  logic v1;
  logic v2;
  logic v3;
  st1_t d1;
  st2_t d2;
  st3_t d3;

  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  qau_mul1 u_mul1 (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(in_valid_i), .data_i(in_data_i), .valid_o(v1), .data_o(d1)
  );

  qau_sum1 u_sum1 (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(v1), .data_i(d1), .valid_o(v2), .data_o(d2)
  );

  qau_mul2 u_mul2 (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(v2), .data_i(d2), .valid_o(v3), .data_o(d3)
  );

  qau_sum2 u_sum2 (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(v3), .data_i(d3), .valid_o(out_valid_o), .data_o(out_data_o)
  );

endmodule

/* rtl/qau_checker.sv */
// Port-level checker for the quaternion unit, bound to the top level.
// Depends on qau_pkg and assert_macros.svh.
`include "assert_macros.svh"

module qau_port_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input qau_pkg::in_t  in_data_i,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input qau_pkg::out_t out_data_o
);
  import qau_pkg::*;

  `QAU_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o)
  `QAU_ASSERT(a_ready_only_stall, clk_i, rst_ni, !in_ready_o |-> out_valid_o && !out_ready_i)
  `QAU_ASSERT(a_empty_after_reset, clk_i, rst_ni, $past(!rst_ni) |-> !out_valid_o)
  `QAU_ASSERT(a_result_stable, clk_i, rst_ni, out_valid_o && !out_ready_i |=> $stable(out_data_o))
  `QAU_ASSERT(a_in_hold, clk_i, rst_ni, in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_data_i))

endmodule

bind quaternion_arithmetic_unit_top qau_port_checker u_qau_checker (.*);

/* test/qau_checker.sv */
// Checker of the quaternion arithmetic unit: predicts each result from the accepted words
// and compares the results in order. Depends on qau_pkg.
module qau_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_ready_i,
  input  qau_pkg::in_t  in_data_i,
  input  logic          out_valid_i,
  input  logic          out_ready_i,
  input  qau_pkg::out_t out_data_i,
  output int            errors_o,
  output int            pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import qau_pkg::*;

  typedef logic signed [63:0] acc_t;

  out_t expected_q[$];

  function automatic acc_t fxmul(input acc_t x, input acc_t y);
    acc_t p;
    p = x * y;
    return p >>> FracBits;
  endfunction

  function automatic acc_t clip(input acc_t v, inout logic ovf);
    if (v > 64'sh7FFF_FFFF) begin
      ovf = 1'b1;
      return 64'sh7FFF_FFFF;
    end
    if (v < -64'sh8000_0000) begin
      ovf = 1'b1;
      return -64'sh8000_0000;
    end
    return v;
  endfunction

  function automatic out_t quat_result(input in_t w);
    acc_t r[9];
    acc_t aw, ax, ay, az, bw, bx, by, bz, tx, ty, tz;
    acc_t xx, yy, zz, xy, xz, yz, wx, wy, wz;
    acc_t one;
    logic ovf;
    out_t o;
    ovf = 1'b0;
    one = acc_t'(1) <<< FracBits;
    aw = acc_t'(w.a_w); ax = acc_t'(w.a_x); ay = acc_t'(w.a_y); az = acc_t'(w.a_z);
    bw = acc_t'(w.b_w); bx = acc_t'(w.b_x); by = acc_t'(w.b_y); bz = acc_t'(w.b_z);
    foreach (r[i]) r[i] = 0;
    case (kind_e'(w.kind))
      KindAdd: begin
        r[0] = aw + bw; r[1] = ax + bx; r[2] = ay + by; r[3] = az + bz;
      end
      KindSub: begin
        r[0] = aw - bw; r[1] = ax - bx; r[2] = ay - by; r[3] = az - bz;
      end
      KindScale: begin
        r[0] = fxmul(aw, bw); r[1] = fxmul(ax, bw);
        r[2] = fxmul(ay, bw); r[3] = fxmul(az, bw);
      end
      KindProduct: begin
        r[0] = fxmul(aw, bw) - fxmul(ax, bx) - fxmul(ay, by) - fxmul(az, bz);
        r[1] = fxmul(aw, bx) + fxmul(ax, bw) + fxmul(ay, bz) - fxmul(az, by);
        r[2] = fxmul(aw, by) + fxmul(ay, bw) + fxmul(az, bx) - fxmul(ax, bz);
        r[3] = fxmul(aw, bz) + fxmul(az, bw) + fxmul(ax, by) - fxmul(ay, bx);
      end
      KindConj: begin
        r[0] = aw; r[1] = -ax; r[2] = -ay; r[3] = -az;
      end
      KindNormSq: begin
        r[0] = fxmul(aw, aw) + fxmul(ax, ax) + fxmul(ay, ay) + fxmul(az, az);
      end
      KindRotate: begin
        tx = clip(2 * (fxmul(ay, bz) - fxmul(az, by)), ovf);
        ty = clip(2 * (fxmul(az, bx) - fxmul(ax, bz)), ovf);
        tz = clip(2 * (fxmul(ax, by) - fxmul(ay, bx)), ovf);
        r[0] = bx + fxmul(aw, tx) + fxmul(ay, tz) - fxmul(az, ty);
        r[1] = by + fxmul(aw, ty) + fxmul(az, tx) - fxmul(ax, tz);
        r[2] = bz + fxmul(aw, tz) + fxmul(ax, ty) - fxmul(ay, tx);
      end
      default: begin
        xx = fxmul(ax, ax); yy = fxmul(ay, ay); zz = fxmul(az, az);
        xy = fxmul(ax, ay); xz = fxmul(ax, az); yz = fxmul(ay, az);
        wx = fxmul(aw, ax); wy = fxmul(aw, ay); wz = fxmul(aw, az);
        r[0] = one - 2 * (yy + zz); r[1] = 2 * (xy + wz); r[2] = 2 * (xz - wy);
        r[3] = 2 * (xy - wz); r[4] = one - 2 * (xx + zz); r[5] = 2 * (yz + wx);
        r[6] = 2 * (xz + wy); r[7] = 2 * (yz - wx); r[8] = one - 2 * (xx + yy);
      end
    endcase
    foreach (r[i]) r[i] = clip(r[i], ovf);
    o.r0 = r[0][31:0]; o.r1 = r[1][31:0]; o.r2 = r[2][31:0];
    o.r3 = r[3][31:0]; o.r4 = r[4][31:0]; o.r5 = r[5][31:0];
    o.r6 = r[6][31:0]; o.r7 = r[7][31:0]; o.r8 = r[8][31:0];
    o.overflow = ovf;
    return o;
  endfunction

  out_t want;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_q.delete();
      errors_o <= 0;
    end else begin
      if (in_valid_i && in_ready_i) expected_q.push_back(quat_result(in_data_i));
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          if (errors_o < 10) $display("unexpected result word %h", out_data_i);
          errors_o <= errors_o + 1;
        end else begin
          want = expected_q.pop_front();
          if (want !== out_data_i) begin
            if (errors_o < 10) begin
              $display("mismatch: expected %h %h %h %h %h %h %h %h %h ovf %b", want.r0,
                       want.r1, want.r2, want.r3, want.r4, want.r5, want.r6, want.r7,
                       want.r8, want.overflow);
              $display("          actual   %h %h %h %h %h %h %h %h %h ovf %b",
                       out_data_i.r0, out_data_i.r1, out_data_i.r2, out_data_i.r3,
                       out_data_i.r4, out_data_i.r5, out_data_i.r6, out_data_i.r7,
                       out_data_i.r8, out_data_i.overflow);
            end
            errors_o <= errors_o + 1;
          end
        end
      end
    end
  end

  assign pending_o = expected_q.size();

endmodule

/* test/testbench.sv */
// Top of the quaternion unit testbench: clock, reset, directed and random stimulus,
// consumer stalls and the verdict. Depends on qau_pkg, qau_checker and the unit.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import qau_pkg::*;

  localparam int NumRandom = 1400;
  localparam int IdleLimit = 2000;

  logic  clk, rst_n, in_valid, in_ready, out_valid, out_ready;
  in_t   in_data;
  out_t  out_data;
  int    errors, pending, idle_cycles;
  logic  hold_off;

  quaternion_arithmetic_unit_top DUT (
    .clk_i(clk), .rst_ni(rst_n), .in_valid_i(in_valid), .in_ready_o(in_ready),
    .in_data_i(in_data), .out_valid_o(out_valid), .out_ready_i(out_ready),
    .out_data_o(out_data)
  );

  qau_checker checker_inst (
    .clk_i(clk), .rst_ni(rst_n), .in_valid_i(in_valid), .in_ready_i(in_ready),
    .in_data_i(in_data), .out_valid_i(out_valid), .out_ready_i(out_ready),
    .out_data_i(out_data), .errors_o(errors), .pending_o(pending)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic fx_t edge_val(input int sel);
    case (sel)
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return 32'sh0001_0000;
      3: return 32'shFFFF_0000;
      4: return 32'sh0000_0000;
      5: return 32'shFFFF_FFFF;
      default: return fx_t'($urandom);
    endcase
  endfunction

  // Mostly values near unit magnitude so rotations stay meaningful.
  function automatic fx_t rand_fx();
    int m;
    m = $urandom_range(0, 9);
    if (m < 6) return fx_t'($signed($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000);
    if (m < 8) return edge_val($urandom_range(0, 5));
    return fx_t'($urandom);
  endfunction

  task automatic send(input in_t w);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  initial begin
    in_t w;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    for (int k = 0; k < 8; k++) begin
      for (int e = 0; e < 3; e++) begin
        w.kind = 3'(k);
        w.a_w = edge_val(e); w.a_x = edge_val(e); w.a_y = edge_val(e + 1);
        w.a_z = edge_val(e + 3); w.b_w = edge_val(e + 1); w.b_x = edge_val(e);
        w.b_y = edge_val(e + 2); w.b_z = edge_val(e + 1);
        send(w);
      end
    end
    for (int n = 0; n < NumRandom; n++) begin
      w.kind = 3'($urandom_range(0, 7));
      w.a_w = rand_fx(); w.a_x = rand_fx(); w.a_y = rand_fx(); w.a_z = rand_fx();
      w.b_w = rand_fx(); w.b_x = rand_fx(); w.b_y = rand_fx(); w.b_z = rand_fx();
      send(w);
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    hold_off = 1'b0;
    wait (rst_n);
    repeat (200) @(posedge clk);
    hold_off <= 1'b1;
    repeat (150) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    int gap;
    out_ready = 1'b0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_ready <= 1'b0;
      end else if (out_ready && out_valid) begin
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
        if (gap != 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
          out_ready <= 1'b1;
        end
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
